// ----- rtl/bitmap_kth_set_bit_select_core_defines.svh -----
// Assertion macros for the bitmap select core.
`ifndef BITMAP_KTH_SET_BIT_SELECT_CORE_DEFINES_SVH
`define BITMAP_KTH_SET_BIT_SELECT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BKSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bkss assertion failed");
`define BKSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bkss assertion failed");
`else
`define BKSS_ASSERT(lbl, prop)
`define BKSS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/bkss_pkg.sv -----
`default_nettype none

package bkss_pkg;

  localparam int unsigned WORD_W        = 64;
  localparam int unsigned BIT_IDX_W     = 6;
  localparam int unsigned RANK_W        = 20;
  localparam int unsigned POS_W         = 20;
  localparam int unsigned TOTAL_W       = 21;
  localparam int unsigned MAX_WORDS_DEF = 16384;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SELECT = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [WORD_W-1:0]   word;
    logic [RANK_W-1:0]   rank;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/bkss_front.sv -----
`default_nettype none

module bkss_front import bkss_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        op_i,
  input  wire logic [WORD_W-1:0] bitmap_word_i,
  input  wire logic [RANK_W-1:0] rank_i,
  output logic                   cmd_valid_o,
  output cmd_t                   cmd_o,
  input  wire logic              cmd_pop_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            queue_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;
  op_e             op_in;
  cmd_t            cmd_in;

  assign op_in       = op_e'(op_i);
  assign in_stall_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  // unused op code is taken and dropped here
  assign push        = in_valid_i && !in_stall_o && (op_in != OP_NONE);
  assign pop         = cmd_pop_i && (cnt_q != '0);
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    cmd_in.op   = op_in;
    cmd_in.word = bitmap_word_i;
    cmd_in.rank = rank_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bkss_back.sv -----
`default_nettype none

module bkss_back import bkss_pkg::*; #(
  parameter int unsigned MaxWords = MAX_WORDS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_valid_i,
  input  wire cmd_t               cmd_i,
  output logic                    cmd_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [POS_W-1:0]        position_o,
  output logic                    found_o,
  output logic [TOTAL_W-1:0]      total_set_o
);

  localparam int unsigned AddrW = (MaxWords > 1) ? $clog2(MaxWords) : 1;
  localparam int unsigned CntW  = $clog2(MaxWords + 1);
  localparam int unsigned PcW   = $clog2(WORD_W + 1);
  localparam int unsigned FullW = AddrW + BIT_IDX_W;
  localparam logic [TOTAL_W-1:0] TotalMax = '1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  function automatic logic [PcW-1:0] popcnt64(input logic [WORD_W-1:0] v);
    logic [PcW-1:0] s;
    s = '0;
    for (int i = 0; i < WORD_W; i++) begin
      s = s + PcW'(v[i]);
    end
    return s;
  endfunction

  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 4'(v[i]);
    end
    return s;
  endfunction

  function automatic logic [2:0] kth8(input logic [7:0] v, input logic [2:0] r);
    logic [3:0] c;
    logic [2:0] res;
    c   = '0;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        if (c == {1'b0, r}) begin
          res = 3'(i);
        end
        c = c + 1'b1;
      end
    end
    return res;
  endfunction

  logic [WORD_W-1:0]  bitmap_mem_q [MaxWords];
  logic [WORD_W-1:0]  rd_data_q;

  state_e             state_q, state_d;
  logic [CntW-1:0]    words_q, words_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [CntW-1:0]    rd_idx_q, rd_idx_d;
  logic [AddrW-1:0]   ck_idx_q, ck_idx_d;
  logic               dvld_q;
  logic [TOTAL_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0]  scan_word_q, scan_word_d;
  logic [AddrW-1:0]   hit_idx_q, hit_idx_d;
  logic [2:0]         byte_q, byte_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               found_q, found_d;
  logic               out_vld_q, out_vld_d;
  logic [POS_W-1:0]   out_pos_q;
  logic               out_found_q;
  logic [TOTAL_W-1:0] out_total_q;

  logic               rd_en;
  logic               mem_we;
  logic               res_load;
  logic [PcW-1:0]     word_pc;
  logic [PcW-1:0]     app_pc;
  logic [TOTAL_W:0]   total_sum;
  logic [7:0]         scan_byte;
  logic [3:0]         byte_pc;
  logic [FullW-1:0]   pos_full;

  assign cmd_pop_o  = (state_q == ST_IDLE) && cmd_valid_i;
  assign mem_we     = cmd_pop_o && (cmd_i.op == OP_APPEND) && (words_q < CntW'(MaxWords));
  assign rd_en      = (state_q == ST_WALK) && (rd_idx_q != words_q);
  assign word_pc    = popcnt64(rd_data_q);
  assign app_pc     = popcnt64(cmd_i.word);
  assign total_sum  = {1'b0, total_q} + (TOTAL_W + 1)'(app_pc);
  assign scan_byte  = scan_word_q[{byte_q, 3'b000} +: 8];
  assign byte_pc    = popcnt8(scan_byte);
  assign pos_full   = {hit_idx_q, byte_q, kth8(scan_byte, rem_q[2:0])};
  assign res_load   = (state_q == ST_DONE) && (!out_vld_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    words_d     = words_q;
    total_d     = total_q;
    rd_idx_d    = rd_idx_q;
    ck_idx_d    = ck_idx_q;
    rem_d       = rem_q;
    scan_word_d = scan_word_q;
    hit_idx_d   = hit_idx_q;
    byte_d      = byte_q;
    pos_d       = pos_q;
    found_d     = found_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o) begin
          unique case (cmd_i.op)
            OP_CLEAR: begin
              words_d = '0;
              total_d = '0;
            end
            OP_APPEND: begin
              if (mem_we) begin
                words_d = words_q + 1'b1;
                total_d = total_sum[TOTAL_W] ? TotalMax : total_sum[TOTAL_W-1:0];
              end
            end
            OP_SELECT: begin
              rem_d    = TOTAL_W'(cmd_i.rank);
              rd_idx_d = '0;
              pos_d    = '0;
              found_d  = 1'b0;
              if (TOTAL_W'(cmd_i.rank) >= total_q) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (rd_en) begin
          rd_idx_d = rd_idx_q + 1'b1;
          ck_idx_d = rd_idx_q[AddrW-1:0];
        end
        if (dvld_q) begin
          if (TOTAL_W'(word_pc) > rem_q) begin
            scan_word_d = rd_data_q;
            hit_idx_d   = ck_idx_q;
            byte_d      = '0;
            state_d     = ST_SCAN;
          end else begin
            rem_d = rem_q - TOTAL_W'(word_pc);
          end
        end else if (!rd_en) begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (TOTAL_W'(byte_pc) > rem_q) begin
          pos_d   = POS_W'(pos_full);
          found_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          rem_d  = rem_q - TOTAL_W'(byte_pc);
          byte_d = byte_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (res_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (res_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      words_q   <= '0;
      total_q   <= '0;
      rd_idx_q  <= '0;
      dvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      words_q   <= words_d;
      total_q   <= total_d;
      rd_idx_q  <= rd_idx_d;
      dvld_q    <= rd_en;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ck_idx_q    <= ck_idx_d;
    rem_q       <= rem_d;
    scan_word_q <= scan_word_d;
    hit_idx_q   <= hit_idx_d;
    byte_q      <= byte_d;
    pos_q       <= pos_d;
    found_q     <= found_d;
    if (res_load) begin
      out_pos_q   <= pos_q;
      out_found_q <= found_q;
      out_total_q <= total_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_mem_q[words_q[AddrW-1:0]] <= cmd_i.word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= bitmap_mem_q[rd_idx_q[AddrW-1:0]];
    end
  end

  assign out_valid_o = out_vld_q;
  assign position_o  = out_pos_q;
  assign found_o     = out_found_q;
  assign total_set_o = out_total_q;

endmodule

`default_nettype wire

// ----- rtl/bitmap_kth_set_bit_select_core.sv -----
// Clear and append: the back end takes each while idle and stays idle, so one item
// a cycle can flow while no select holds it. Select: the wait for a hit in
// stored word W is set by the single read port of the bitmap memory (one word a
// cycle) plus up to eight byte steps; the back end takes no other item until the
// answer is loaded. A rank at or above the set-bit total skips the walk.
// Reset (async, active low) clears the queue, word count, total, FSM and out valid.
`default_nettype none

`include "bitmap_kth_set_bit_select_core_defines.svh"

module bitmap_kth_set_bit_select_core import bkss_pkg::*; #(
  parameter int unsigned MaxWords = MAX_WORDS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [WORD_W-1:0]  bitmap_word_i,
  input  wire logic [RANK_W-1:0]  rank_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [POS_W-1:0]        position_o,
  output logic                    found_o,
  output logic [TOTAL_W-1:0]      total_set_o
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  bkss_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .bitmap_word_i (bitmap_word_i),
    .rank_i        (rank_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  bkss_back #(
    .MaxWords (MaxWords)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .position_o  (position_o),
    .found_o     (found_o),
    .total_set_o (total_set_o)
  );

  `BKSS_ASSERT(a_notfound_pos_zero, !(out_valid_o && !found_o) || (position_o == '0))
  `BKSS_ASSERT(a_found_needs_bits, !(out_valid_o && found_o) || (total_set_o != '0))
  `BKSS_ASSERT(a_empty_queue_no_stall, cmd_valid || !in_stall_o)
  `BKSS_ASSERT_NEXT(a_pop_needs_item, cmd_pop, $past(cmd_valid))

endmodule

`default_nettype wire

// ----- tb/sv/bitmap_kth_set_bit_select_core_tb.sv -----
module bitmap_kth_set_bit_select_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bkss_pkg::*;

  localparam int unsigned TotalMax    = (1 << TOTAL_W) - 1;
  localparam int unsigned LimitCycles = 1_200_000;

  typedef struct {
    logic [POS_W-1:0]   position;
    logic               found;
    logic [TOTAL_W-1:0] total_set;
  } answer_t;

  // Shadow copy of the flag store; works out the answer to each select.
  class bitmap_rank_sb;
    logic [WORD_W-1:0] stored_words[$];
    int unsigned       set_total;
    answer_t           answers_due[$];
    int unsigned       errors, items, appends, dropped, selects, checked, misses;

    function void note_item(op_e op, logic [WORD_W-1:0] word, logic [RANK_W-1:0] rank);
      answer_t     ans;
      int unsigned seen;
      int unsigned ones;
      items++;
      case (op)
        OP_CLEAR: begin
          stored_words.delete();
          set_total = 0;
        end
        OP_APPEND: begin
          appends++;
          if (stored_words.size() < MAX_WORDS_DEF) begin
            stored_words = {stored_words, word};
            set_total += $countones(word);
            if (set_total > TotalMax) set_total = TotalMax;
          end else begin
            dropped++;
          end
        end
        OP_SELECT: begin
          selects++;
          ans.position  = '0;
          ans.found     = 1'b0;
          ans.total_set = TOTAL_W'(set_total);
          seen = 0;
          foreach (stored_words[i]) begin
            ones = $countones(stored_words[i]);
            if (!ans.found && seen + ones > rank) begin
              for (int b = 0; b < WORD_W; b++) begin
                if (stored_words[i][b]) begin
                  if (!ans.found && seen == rank) begin
                    ans.found    = 1'b1;
                    ans.position = POS_W'(i * WORD_W + b);
                  end
                  seen++;
                end
              end
            end else if (!ans.found) begin
              seen += ones;
            end
          end
          if (!ans.found) misses++;
          answers_due = {answers_due, ans};
        end
        default: begin
        end
      endcase
    endfunction

    function void check_answer(logic [POS_W-1:0] position, logic found,
                               logic [TOTAL_W-1:0] total_set);
      answer_t want;
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: answer with none due: position %0d found %0b total_set %0d",
                 $time, position, found, total_set);
        return;
      end
      want = answers_due.pop_front();
      checked++;
      if (position !== want.position) begin
        errors++;
        $display("%0t: position expected %0d, got %0d", $time, want.position, position);
      end
      if (found !== want.found) begin
        errors++;
        $display("%0t: found expected %0b, got %0b", $time, want.found, found);
      end
      if (total_set !== want.total_set) begin
        errors++;
        $display("%0t: total_set expected %0d, got %0d", $time, want.total_set, total_set);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         op_i;
  logic [WORD_W-1:0]  bitmap_word_i;
  logic [RANK_W-1:0]  rank_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [POS_W-1:0]   position_o;
  logic               found_o;
  logic [TOTAL_W-1:0] total_set_o;

  bitmap_rank_sb sb;
  bit            quiet_run;
  int unsigned   hold_req;

  bitmap_kth_set_bit_select_core #(
    .MaxWords(MAX_WORDS_DEF)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .bitmap_word_i(bitmap_word_i),
    .rank_i       (rank_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .position_o   (position_o),
    .found_o      (found_o),
    .total_set_o  (total_set_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(LimitCycles * 12);
    $display("bitmap_kth_set_bit_select_core_tb failed");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet_run && ($urandom_range(0, 99) < 10);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_answer(position_o, found_o, total_set_o);
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, WORD_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_item(op_e op, logic [WORD_W-1:0] word, logic [RANK_W-1:0] rank);
    @(negedge clk_i);
    while (!quiet_run && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    bitmap_word_i <= word;
    rank_i        <= rank;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    sb.note_item(op, word, rank);
  endtask

  initial begin
    int unsigned       pick;
    logic [RANK_W-1:0] want_rank;
    sb            = new();
    quiet_run     = 1'b0;
    hold_req      = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OP_CLEAR;
    bitmap_word_i = '0;
    rank_i        = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty store, word edges, last set bit, rank past total, unused op
    send_item(OP_SELECT, rand_word(), '0);
    send_item(OP_APPEND, '0, 20'($urandom));
    send_item(OP_APPEND, '1, 20'($urandom));
    send_item(OP_APPEND, 64'h8000_0000_0000_0001, 20'($urandom));
    send_item(OP_SELECT, rand_word(), 20'd0);
    send_item(OP_SELECT, rand_word(), 20'd63);
    send_item(OP_SELECT, rand_word(), 20'd64);
    send_item(OP_SELECT, rand_word(), 20'd65);
    send_item(OP_SELECT, rand_word(), 20'd66);
    send_item(OP_SELECT, rand_word(), 20'hFFFFF);
    send_item(OP_NONE, '1, '1);
    send_item(OP_SELECT, '0, 20'd65);
    send_item(OP_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    send_item(OP_SELECT, rand_word(), 20'd66);
    send_item(OP_SELECT, rand_word(), 20'd97);
    send_item(OP_CLEAR, '1, '1);
    send_item(OP_SELECT, rand_word(), 20'd0);
    send_item(OP_APPEND, 64'h8000_0000_0000_0000, 20'($urandom));
    send_item(OP_SELECT, rand_word(), 20'd0);
    send_item(OP_SELECT, rand_word(), 20'd1);

    // back-pressure: output held off while selects keep coming
    send_item(OP_CLEAR, rand_word(), 20'($urandom));
    repeat (4) send_item(OP_APPEND, {$urandom, $urandom}, 20'($urandom));
    hold_req = 400;
    repeat (10) send_item(OP_SELECT, rand_word(), 20'($urandom_range(0, sb.set_total)));

    for (int n = 0; n < 70; n++) begin
      quiet_run = (n >= 25 && n < 50);
      pick = $urandom_range(0, 99);
      if (sb.stored_words.size() >= 48 || pick < 4) begin
        send_item(OP_CLEAR, rand_word(), 20'($urandom));
      end else if (pick < 45) begin
        send_item(OP_APPEND, rand_word(), 20'($urandom));
      end else if (pick < 96) begin
        if ($urandom_range(0, 3) == 0) want_rank = 20'($urandom);
        else want_rank = 20'($urandom_range(0, sb.set_total));
        send_item(OP_SELECT, rand_word(), want_rank);
      end else begin
        send_item(OP_NONE, rand_word(), 20'($urandom));
      end
    end
    quiet_run = 1'b0;

    send_item(OP_CLEAR, rand_word(), 20'($urandom));
    send_item(OP_SELECT, rand_word(), 20'd0);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.answers_due.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("Sent %0d items: %0d appends (%0d dropped when full), %0d selects.",
             sb.items, sb.appends, sb.dropped, sb.selects);
    $display("Checked %0d answers, %0d of them not-found, %0d mismatches.",
             sb.checked, sb.misses, sb.errors);
    if (sb.errors == 0) begin
      $display("bitmap_kth_set_bit_select_core_tb passed");
    end else begin
      $display("bitmap_kth_set_bit_select_core_tb failed");
    end
    $finish;
  end

endmodule
